@@ rtl/msb_first_bit_packer_core_defines.svh @@
// Assertion macros shared by the bit packer controller and datapath.
// Every macro expects a clock named clk and a reset named rst in scope.
`ifndef MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbp_pkg.sv @@
// Package for the MSB-first bit packer: codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package mbp_pkg;

  localparam int unsigned SHIFT_BITS = 72;
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [6:0] MAX_FIELD_WIDTH = 7'd64;
  localparam logic [6:0] SHIFT_SPAN = 7'd72;

  localparam logic ACTION_APPEND = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_WIDTH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic final_result;
  } dp_stat_t;

endpackage

@@ rtl/mbp_in_if.sv @@
// Input channel of the bit packer: handshake plus action, value and width.
// Depends on nothing.
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] field_value;
  logic [6:0]  width;

  modport source(output valid, action, field_value, width, input ready);
  modport sink(input valid, action, field_value, width, output ready);
endinterface

@@ rtl/mbp_out_if.sv @@
// Result channel of the bit packer: handshake plus byte, flags and bit total.
// Depends on nothing.
interface mbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        status;
  logic [31:0] total_bits;
  logic        last;

  modport source(output valid, out_byte, byte_valid, status, total_bits, last,
                 input ready);
  modport sink(input valid, out_byte, byte_valid, status, total_bits, last,
               output ready);
endinterface

@@ rtl/mbp_ctrl.sv @@
// Controller of the bit packer: idle and emit states, issues load and emit
// commands. Depends on mbp_pkg and the assertion macro header.
`include "msb_first_bit_packer_core_defines.svh"

module mbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mbp_pkg::dp_stat_t stat,
  output mbp_pkg::dp_cmd_t  cmd
);
  import mbp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free && stat.final_result) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_EMIT: begin
        cmd.emit = stat.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `MBP_ASSERT_NEXT(a_load_enters_emit, cmd.load, state == ST_EMIT,
                   "Accepted transaction did not start emitting.")
  `MBP_ASSERT_NEXT(a_final_returns_idle, cmd.emit && stat.final_result,
                   state == ST_IDLE, "Final result did not return to idle.")
  `MBP_ASSERT_SAME(a_emit_needs_slot, cmd.emit, stat.slot_free,
                   "Result written while the output register was busy.")

endmodule

@@ rtl/mbp_datapath.sv @@
// Datapath of the bit packer: 72-bit left-aligned shift register holding the
// pending bits, bit total, result counter and output register. Uses mbp_pkg.
`include "msb_first_bit_packer_core_defines.svh"

module mbp_datapath #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  mbp_pkg::dp_cmd_t  cmd,
  output mbp_pkg::dp_stat_t stat,
  input  logic              action,
  input  logic [63:0]       field_value,
  input  logic [6:0]        width,
  mbp_out_if.source         out_ch
);
  import mbp_pkg::*;

  logic [SHIFT_BITS-1:0] shreg;
  logic [2:0]            pcnt;
  logic [COUNT_BITS-1:0] bit_total;
  logic [3:0]            res_left;
  logic                  res_byte;
  logic                  res_status;

  logic                  out_valid;
  logic [7:0]            ob_byte;
  logic                  ob_bv;
  logic                  ob_status;
  logic [31:0]           ob_total;
  logic                  ob_last;

  logic [6:0]            fill;
  logic [3:0]            nbytes;
  logic [6:0]            shamt;
  logic [63:0]           vmask;
  logic [SHIFT_BITS-1:0] merged;
  logic [63:0]           total_wide;
  logic                  bad_width;

  assign bad_width = width > MAX_FIELD_WIDTH;
  assign fill = {4'd0, pcnt} + width;
  assign nbytes = fill[6:3];
  assign shamt = SHIFT_SPAN - {4'd0, pcnt} - width;
  assign vmask = ~({64{1'b1}} << width);
  assign merged = {8'd0, field_value & vmask} << shamt;
  assign total_wide = 64'(bit_total);

  assign stat.slot_free = !out_valid || out_ch.ready;
  assign stat.final_result = res_left == 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shreg <= '0;
      pcnt <= '0;
      bit_total <= '0;
      res_left <= '0;
      res_byte <= 1'b0;
      res_status <= STATUS_OK;
    end else if (cmd.load) begin
      if (action == ACTION_FLUSH) begin
        res_left <= 4'd1;
        res_byte <= pcnt != 3'd0;
        res_status <= STATUS_OK;
        pcnt <= '0;
      end else if (bad_width) begin
        res_left <= 4'd1;
        res_byte <= 1'b0;
        res_status <= STATUS_BAD_WIDTH;
      end else begin
        shreg <= shreg | merged;
        pcnt <= fill[2:0];
        bit_total <= bit_total + COUNT_BITS'(width);
        res_left <= (nbytes == 4'd0) ? 4'd1 : nbytes;
        res_byte <= nbytes != 4'd0;
        res_status <= STATUS_OK;
      end
    end else if (cmd.emit) begin
      res_left <= res_left - 4'd1;
      if (res_byte) begin
        shreg <= shreg << BYTE_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ob_byte <= res_byte ? shreg[SHIFT_BITS-1 -: BYTE_BITS] : 8'd0;
      ob_bv <= res_byte;
      ob_status <= res_status;
      ob_total <= total_wide[31:0];
      ob_last <= res_left == 4'd1;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.out_byte = ob_byte;
  assign out_ch.byte_valid = ob_bv;
  assign out_ch.status = ob_status;
  assign out_ch.total_bits = ob_total;
  assign out_ch.last = ob_last;

  `MBP_ASSERT_SAME(a_emit_has_work, cmd.emit, res_left != 4'd0,
                   "Result written with no result left for the transaction.")
  `MBP_ASSERT_SAME(a_load_when_drained, cmd.load, res_left == 4'd0,
                   "New transaction loaded before the previous one drained.")
  `MBP_ASSERT_NEXT(a_emit_fills_slot, cmd.emit, out_valid,
                   "Written result did not appear on the output register.")

endmodule

@@ rtl/msb_first_bit_packer_core.sv @@
// Top level of the MSB-first bit packer: ties controller and datapath to the
// two channels. Depends on mbp_pkg, mbp_in_if, mbp_out_if, mbp_ctrl, mbp_datapath.
//
//   Channel  Role   Transaction carries
//   in_ch    sink   action, field_value, width
//   out_ch   source out_byte, byte_valid, status, total_bits, last
//
// An input transaction is loaded and then emits its results one at a time; an
// append completing k bytes gives max(k, 1) results, at most 8.
// The single output register takes one result per cycle while it is free.
// Reset is synchronous and clears pending bits, the bit total and all control.
// A stalled output holds the emit state; input is taken only when idle.
module msb_first_bit_packer_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  mbp_in_if.sink    in_ch,
  mbp_out_if.source out_ch
);
  import mbp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ctrl_ready;

  assign in_ch.ready = ctrl_ready;

  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbp_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (in_ch.action),
    .field_value (in_ch.field_value),
    .width       (in_ch.width),
    .out_ch      (out_ch)
  );

endmodule
